@@ sv/aalr_pkg.sv @@
// Shared types and constants for the antialiased line rasterizer.
package aalr_pkg;

    localparam int COLOR_BITS  = 24;
    localparam int SHADE_BITS  = 4;
    localparam int SHADE_STEPS = 10;
    localparam logic [COLOR_BITS-1:0] WHITE = 24'hFFFFFF;

    // s_tuser item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Which pixel the datapath loads into the output register
    typedef enum logic [1:0] {
        SEL_END0,
        SEL_END1,
        SEL_LO,
        SEL_HI
    } pix_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     start_load;
        logic     div_step;
        logic     div_finish;
        logic     out_load;
        pix_sel_t out_sel;
        logic     advance;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic coincident;
        logic adjacent;
        logic smooth;
        logic last_col;
        logic div_done;
    } status_t;

endpackage

@@ sv/aalr_dpath.sv @@
// Datapath: endpoint setup, slope divider, column stepper, shading and output register.
module aalr_dpath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16,
    parameter int IN_W       = 80,
    parameter int OUT_W      = 56
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [IN_W-1:0]      s_tdata,
    input  aalr_pkg::cmd_t       cmd,
    output aalr_pkg::status_t    status,
    output logic [OUT_W-1:0]     m_tdata,
    output logic                 m_tlast
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int YW    = C + F;
    localparam int CNT_W = $clog2(F + 2);
    localparam int CB    = aalr_pkg::COLOR_BITS;
    localparam int SB    = aalr_pkg::SHADE_BITS;

    // Input fields
    logic [C-1:0]  sx, sy, ex, ey;
    logic [CB-1:0] in_color;
    logic          in_aa;

    assign sx       = s_tdata[C-1:0];
    assign sy       = s_tdata[2*C-1:C];
    assign ex       = s_tdata[3*C-1:2*C];
    assign ey       = s_tdata[4*C-1:3*C];
    assign in_color = s_tdata[4*C+CB-1:4*C];
    assign in_aa    = s_tdata[4*C+CB];

    // Endpoint setup: steep swap, order by major axis, deltas
    logic [C-1:0] adx, ady;
    logic         steep;
    logic [C-1:0] pa0, pb0, pa1, pb1;
    logic [C-1:0] oa0, ob0, oa1, ob1;
    logic [C-1:0] dx_c, dy_abs_c;
    logic         neg_c;

    always_comb begin
        adx   = (sx > ex) ? (sx - ex) : (ex - sx);
        ady   = (sy > ey) ? (sy - ey) : (ey - sy);
        steep = ady > adx;
        pa0   = steep ? sy : sx;
        pb0   = steep ? sx : sy;
        pa1   = steep ? ey : ex;
        pb1   = steep ? ex : ey;
        if (pa0 > pa1) begin
            oa0 = pa1;
            ob0 = pb1;
            oa1 = pa0;
            ob1 = pb0;
        end else begin
            oa0 = pa0;
            ob0 = pb0;
            oa1 = pa1;
            ob1 = pb1;
        end
        dx_c     = oa1 - oa0;
        neg_c    = ob1 < ob0;
        dy_abs_c = neg_c ? (ob0 - ob1) : (ob1 - ob0);
    end

    // Line registers
    logic [C-1:0]   a0_reg, b0_reg, a1_reg, b1_reg, dx_reg;
    logic           steep_reg, smooth_reg, neg_reg, coinc_reg;
    logic [CB-1:0]  color_reg;
    logic [C:0]     rem_reg;
    logic [F:0]     quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [C-1:0]   cur_x_reg, stop_x_reg;
    logic [YW-1:0]  y_acc_reg;
    logic [F+1:0]   slope_reg;

    // Divider step: restoring, one quotient bit per cycle
    logic         div_ge;
    logic [C:0]   rem_sub;
    logic [F+1:0] slope_c;
    logic [YW-1:0] y_init;

    always_comb begin
        div_ge  = rem_reg >= {1'b0, dx_reg};
        rem_sub = div_ge ? (rem_reg - {1'b0, dx_reg}) : rem_reg;
        slope_c = neg_reg ? ((F+2)'(0) - {1'b0, quo_reg}) : {1'b0, quo_reg};
        y_init  = {b0_reg, F'(0)} + {{(YW-F-2){slope_c[F+1]}}, slope_c};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.start_load) begin
            cnt_reg <= CNT_W'(F + 1);
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_load) begin
            a0_reg     <= oa0;
            b0_reg     <= ob0;
            a1_reg     <= oa1;
            b1_reg     <= ob1;
            dx_reg     <= dx_c;
            steep_reg  <= steep;
            smooth_reg <= in_aa;
            neg_reg    <= neg_c;
            coinc_reg  <= (sx == ex) && (sy == ey);
            color_reg  <= in_color;
            rem_reg    <= {1'b0, dy_abs_c};
            quo_reg    <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= {rem_sub[C-1:0], 1'b0};
            quo_reg <= {quo_reg[F-1:0], div_ge};
        end
    end

    // Column stepper
    always_ff @(posedge aclk) begin
        if (cmd.div_finish) begin
            slope_reg  <= slope_c;
            y_acc_reg  <= y_init;
            cur_x_reg  <= a0_reg + C'(1);
            stop_x_reg <= a1_reg;
        end else if (cmd.advance) begin
            cur_x_reg <= cur_x_reg + C'(1);
            y_acc_reg <= y_acc_reg + {{(YW-F-2){slope_reg[F+1]}}, slope_reg};
        end
    end

    // Shade levels from the y fraction
    logic [C-1:0]   yi;
    logic [F-1:0]   fr;
    logic [F:0]     fr_comp;
    logic [F+3:0]   lo_sum, hi_sum;
    logic [SB-1:0]  shade_lo, shade_hi;
    logic           white;
    logic           last_col;

    always_comb begin
        yi       = y_acc_reg[YW-1:F];
        fr       = y_acc_reg[F-1:0];
        fr_comp  = ((F+1)'(1) << F) - {1'b0, fr};
        lo_sum   = {4'b0, fr} * (F+4)'(aalr_pkg::SHADE_STEPS) + ((F+4)'(1) << (F-1));
        hi_sum   = {3'b0, fr_comp} * (F+4)'(aalr_pkg::SHADE_STEPS) + ((F+4)'(1) << (F-1));
        white    = color_reg == aalr_pkg::WHITE;
        shade_lo = white ? '0 : lo_sum[F+3:F];
        shade_hi = white ? '0 : hi_sum[F+3:F];
        last_col = ({1'b0, cur_x_reg} + (C+1)'(1)) >= {1'b0, stop_x_reg};
    end

    // Pixel selection, axes swapped back
    logic [C-1:0]  sel_a, sel_b;
    logic [SB-1:0] sel_shade;
    logic          sel_last;

    always_comb begin
        case (cmd.out_sel)
            aalr_pkg::SEL_END0: begin
                sel_a     = a0_reg;
                sel_b     = b0_reg;
                sel_shade = '0;
                sel_last  = coinc_reg;
            end
            aalr_pkg::SEL_END1: begin
                sel_a     = a1_reg;
                sel_b     = b1_reg;
                sel_shade = '0;
                sel_last  = dx_reg <= C'(1);
            end
            aalr_pkg::SEL_LO: begin
                sel_a     = cur_x_reg;
                sel_b     = yi;
                sel_shade = smooth_reg ? shade_lo : '0;
                sel_last  = !smooth_reg && last_col;
            end
            aalr_pkg::SEL_HI: begin
                sel_a     = cur_x_reg;
                sel_b     = yi + C'(1);
                sel_shade = shade_hi;
                sel_last  = last_col;
            end
            default: begin
                sel_a     = cur_x_reg;
                sel_b     = yi;
                sel_shade = '0;
                sel_last  = 1'b0;
            end
        endcase
    end

    // Output register
    logic [C-1:0]  px_reg, py_reg;
    logic [SB-1:0] shade_reg;
    logic [CB-1:0] pcolor_reg;
    logic          plast_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            px_reg     <= steep_reg ? sel_b : sel_a;
            py_reg     <= steep_reg ? sel_a : sel_b;
            shade_reg  <= sel_shade;
            pcolor_reg <= color_reg;
            plast_reg  <= sel_last;
        end
    end

    assign m_tdata = OUT_W'({pcolor_reg, shade_reg, py_reg, px_reg});
    assign m_tlast = plast_reg;

    // Status
    assign status.coincident = coinc_reg;
    assign status.adjacent   = dx_reg <= C'(1);
    assign status.smooth     = smooth_reg;
    assign status.last_col   = last_col;
    assign status.div_done   = cnt_reg == '0;

endmodule

@@ sv/aalr_ctrl.sv @@
// Controller: sequences line setup, division and per-column pixel transfers.
module aalr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  aalr_pkg::status_t   status,
    output aalr_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_END0,
        ST_END1,
        ST_DIV,
        ST_HI
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   busy_reg, busy_next;
    logic   out_free, accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        cmd.start_load = 1'b0;
        cmd.div_step   = 1'b0;
        cmd.div_finish = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.out_sel    = aalr_pkg::SEL_LO;
        cmd.advance    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == aalr_pkg::KIND_START) begin
                        cmd.start_load = 1'b1;
                        busy_next      = 1'b0;
                        state_next     = ST_END0;
                    end else if (busy_reg) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = aalr_pkg::SEL_LO;
                        if (status.smooth) begin
                            state_next = ST_HI;
                        end else begin
                            cmd.advance = 1'b1;
                            busy_next   = !status.last_col;
                        end
                    end
                end
            end
            ST_END0: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = aalr_pkg::SEL_END0;
                    state_next   = status.coincident ? ST_IDLE : ST_END1;
                end
            end
            ST_END1: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = aalr_pkg::SEL_END1;
                    state_next   = status.adjacent ? ST_IDLE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    cmd.div_finish = 1'b1;
                    busy_next      = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_HI: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = aalr_pkg::SEL_HI;
                    cmd.advance  = 1'b1;
                    busy_next    = !status.last_col;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid follows loads and transfers
    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            busy_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

@@ sv/antialiased_line_rasterizer.sv @@
// Top level of the antialiased line rasterizer: controller plus datapath.
// Start transfer: endpoints registered in END0 then END1 as the output permits, then the
//   divider runs; the next transfer is accepted once the controller is back in idle.
// Advance transfer: first pixel registered at the accepting edge, valid the next cycle; one
//   transfer per cycle in plain mode unless the output stalls; two pixels each when antialiased.
// Reset (aresetn low, synchronous) returns to idle with no line active and no pending output.
module antialiased_line_rasterizer #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // start_x, start_y, end_x, end_y, line_color, antialias (low bit up), zero padded
    input  logic [((4*COORD_BITS+aalr_pkg::COLOR_BITS+1+7)/8)*8-1:0] s_tdata,
    // kind: 0 = start line, 1 = advance one column
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // pixel_x, pixel_y, shade, pixel_color (low bit up), zero padded
    output logic [((2*COORD_BITS+aalr_pkg::SHADE_BITS+aalr_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
    output logic                    m_tlast
);

    localparam int IN_W  = ((4*COORD_BITS + aalr_pkg::COLOR_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_W =
        ((2*COORD_BITS + aalr_pkg::SHADE_BITS + aalr_pkg::COLOR_BITS + 7) / 8) * 8;

    aalr_pkg::cmd_t    cmd;
    aalr_pkg::status_t status;

    aalr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    aalr_dpath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule
